// ----- rtl/assert_macros.svh -----
// Assertion macros for the joystick input conditioner RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("joystick conditioner: property failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("joystick conditioner: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ----- rtl/jic_pkg.sv -----
// Shared constants and types of the joystick input conditioner
package jic_pkg;

  localparam int AXIS_COUNT    = 4;
  localparam int BUTTON_COUNT  = 4;
  localparam int FIELD_AXES    = 4;
  localparam int FIELD_BUTTONS = 4;

  localparam int CODE_W    = 16;
  localparam int CAL_W     = 48;
  localparam int CMD_W     = 11;
  localparam int TIME_W    = 32;
  localparam int WIN_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_LEFT_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_LEFT_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_RIGHT_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_RIGHT_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd4;

  // centre 166, minimum 0, maximum 333
  localparam logic [CAL_W-1:0] CAL_RESET      = 48'h00A6_0000_014D;
  localparam logic [WIN_W-1:0] DEBOUNCE_RESET = 16'd100;

  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 17;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam int VAL_W  = 11;
  localparam int DIFF_W = 17;
  localparam int PROD_W = 26;
  localparam int MAP_W  = 26;

  // divide by 160 as a shift by 5 and a reciprocal multiply by 1/5
  localparam int                SCALE_SHIFT = 5;
  localparam int                RECIP_W     = 16;
  localparam logic [RECIP_W-1:0] RECIP_FIVE = 16'd52429;
  localparam int                RECIP_SHIFT = 18;

  localparam int SCALE_DIV   = 160;
  localparam int NARROW_SPAN = 10;
  localparam int NARROW_DEN  = 333;
  localparam int NARROW_GAIN = 1000;
  localparam int HALF_GAIN   = 500;
  localparam int CMD_MIN     = 1000;
  localparam int CMD_MAX     = 2000;
  localparam int CMD_CENTRE  = 1500;
  localparam int DEAD_LO     = 1492;
  localparam int DEAD_HI     = 1508;
  localparam int INVERT_SUM  = 3000;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_status_t;

endpackage

// ----- rtl/jic_divider.sv -----
// Restoring serial divider, one quotient bit per cycle
module jic_divider import jic_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_NUM_W-1:0] quo,
  output logic                 done
);

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_NUM_W - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] divisor;
  logic [DIV_DEN_W:0]   rem_shift;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  assign rem_shift = {rem, quo[DIV_NUM_W-1]};
  assign trial     = rem_shift - {1'b0, divisor};
  assign fits      = !trial[DIV_DEN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      quo     <= num;
      divisor <= den;
    end else if (busy) begin
      rem <= fits ? trial[DIV_DEN_W-1:0] : rem_shift[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/jic_axis_lane.sv -----
// One axis lane: scale, piecewise map, deadband, invert and clamp
module jic_axis_lane import jic_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [CODE_W-1:0] code,
  input  logic [CAL_W-1:0]         cal,
  output logic [CMD_W-1:0]         cmd,
  output lane_status_t             status
);

  localparam logic [2:0] L_IDLE  = 3'd0;
  localparam logic [2:0] L_SCALE = 3'd1;
  localparam logic [2:0] L_MUL   = 3'd2;
  localparam logic [2:0] L_D2GO  = 3'd3;
  localparam logic [2:0] L_D2    = 3'd4;
  localparam logic [2:0] L_FIN   = 3'd5;
  localparam logic [2:0] L_DONE  = 3'd6;

  logic [2:0] state;

  logic signed [CODE_W-1:0] code_r;
  logic signed [CODE_W+1:0] code_x;
  logic signed [CODE_W+1:0] code3;
  logic                     code3_neg;
  logic [CODE_W+1:0]        code3_mag;
  logic [CODE_W+1-SCALE_SHIFT:0]         code3_top;
  logic [CODE_W+1-SCALE_SHIFT+RECIP_W:0] recip_prod;

  logic signed [CODE_W-1:0] centre;
  logic signed [CODE_W-1:0] lo;
  logic signed [CODE_W-1:0] hi;
  logic signed [DIFF_W-1:0] centre_x;
  logic signed [DIFF_W-1:0] lo_x;
  logic signed [DIFF_W-1:0] hi_x;
  logic signed [DIFF_W-1:0] span_lo;
  logic signed [DIFF_W-1:0] span_hi;
  logic                     narrow;
  logic                     upper;

  logic signed [VAL_W-1:0]  val;
  logic signed [VAL_W-1:0]  q1_s;
  logic signed [DIFF_W-1:0] val_x;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] diff_x;
  logic signed [PROD_W-1:0] gain_x;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_neg;
  logic [PROD_W-1:0]        prod_mag;
  logic [DIV_DEN_W-1:0]     den;
  logic signed [MAP_W-1:0]  base;
  logic signed [MAP_W-1:0]  q2_s;
  logic signed [MAP_W-1:0]  m;
  logic signed [MAP_W-1:0]  m_clamp;
  logic signed [MAP_W-1:0]  m_dead;
  logic signed [MAP_W-1:0]  m_inv;
  logic [CMD_W-1:0]         cmd_next;

  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quo;
  logic                 div_done;

  assign centre = cal[47:32];
  assign lo     = cal[31:16];
  assign hi     = cal[15:0];

  assign centre_x = DIFF_W'(centre);
  assign lo_x     = DIFF_W'(lo);
  assign hi_x     = DIFF_W'(hi);
  assign span_lo  = centre_x - lo_x;
  assign span_hi  = hi_x - centre_x;
  assign narrow   = (span_lo < DIFF_W'(NARROW_SPAN)) || (span_hi < DIFF_W'(NARROW_SPAN));

  // code * 3 as shift and add
  assign code_x    = (CODE_W + 2)'(code_r);
  assign code3     = (code_x <<< 1) + code_x;
  assign code3_neg = code3[CODE_W+1];
  assign code3_mag = code3_neg ? -code3 : code3;

  // magnitude / 160: drop 5 bits, then multiply by the reciprocal of 5
  assign code3_top  = code3_mag[CODE_W+1:SCALE_SHIFT];
  assign recip_prod = {{RECIP_W{1'b0}}, code3_top}
                    * {{(CODE_W+2-SCALE_SHIFT){1'b0}}, RECIP_FIVE};

  assign q1_s  = {1'b0, recip_prod[RECIP_SHIFT+VAL_W-2:RECIP_SHIFT]};
  assign val_x = DIFF_W'(val);
  assign upper = val_x >= centre_x;

  always_comb begin
    if (narrow) begin
      diff = val_x;
    end else if (upper) begin
      diff = val_x - centre_x;
    end else begin
      diff = val_x - lo_x;
    end
  end

  assign diff_x = PROD_W'(diff);
  assign gain_x = narrow ? PROD_W'(NARROW_GAIN) : PROD_W'(HALF_GAIN);

  assign prod_neg = prod[PROD_W-1];
  assign prod_mag = prod_neg ? -prod : prod;
  assign q2_s     = MAP_W'(div_quo);

  assign div_start = (state == L_D2GO);
  assign div_num   = prod_mag[DIV_NUM_W-1:0];
  assign div_den   = den;

  always_comb begin
    m_clamp = m;
    if (narrow) begin
      if (m < MAP_W'(CMD_MIN)) begin
        m_clamp = MAP_W'(CMD_MIN);
      end else if (m > MAP_W'(CMD_MAX)) begin
        m_clamp = MAP_W'(CMD_MAX);
      end
    end
    m_dead = m_clamp;
    if (m_clamp > MAP_W'(DEAD_LO) && m_clamp < MAP_W'(DEAD_HI)) begin
      m_dead = MAP_W'(CMD_CENTRE);
    end
    m_inv = MAP_W'(INVERT_SUM) - m_dead;
    if (m_inv < MAP_W'(CMD_MIN)) begin
      cmd_next = CMD_W'(CMD_MIN);
    end else if (m_inv > MAP_W'(CMD_MAX)) begin
      cmd_next = CMD_W'(CMD_MAX);
    end else begin
      cmd_next = m_inv[CMD_W-1:0];
    end
  end

  jic_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      case (state)
        L_IDLE, L_DONE: begin
          if (start) state <= L_SCALE;
        end
        L_SCALE: state <= L_MUL;
        L_MUL:   state <= L_D2GO;
        L_D2GO:  state <= L_D2;
        L_D2: begin
          if (div_done) state <= L_FIN;
        end
        L_FIN:   state <= L_DONE;
        default: state <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && (state == L_IDLE || state == L_DONE)) begin
      code_r <= code;
    end
    if (state == L_SCALE) begin
      val <= code3_neg ? -q1_s : q1_s;
    end
    if (state == L_MUL) begin
      prod <= diff_x * gain_x;
      if (narrow) begin
        den <= DIV_DEN_W'(NARROW_DEN);
      end else if (upper) begin
        den <= span_hi;
      end else begin
        den <= span_lo;
      end
      base <= (narrow || !upper) ? MAP_W'(CMD_MIN) : MAP_W'(CMD_CENTRE);
    end
    if (state == L_D2 && div_done) begin
      m <= prod_neg ? base - q2_s : base + q2_s;
    end
    if (state == L_FIN) begin
      cmd <= cmd_next;
    end
  end

  assign status.busy = (state != L_IDLE) && (state != L_DONE);
  assign status.done = (state == L_DONE);

endmodule

// ----- rtl/jic_debounce.sv -----
// Button debounce with hold-off window and edge flags
module jic_debounce import jic_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     update,
  input  logic [FIELD_BUTTONS-1:0] pins,
  input  logic [TIME_W-1:0]        now,
  input  logic [WIN_W-1:0]         window,
  output logic [FIELD_BUTTONS-1:0] stable_out,
  output logic [FIELD_BUTTONS-1:0] pressed,
  output logic [FIELD_BUTTONS-1:0] released
);

  logic [BUTTON_COUNT-1:0] stable;
  logic [BUTTON_COUNT-1:0] last_level;
  logic [BUTTON_COUNT-1:0] sample;
  logic [BUTTON_COUNT-1:0] take;
  logic [BUTTON_COUNT-1:0] stable_next;
  logic [BUTTON_COUNT-1:0] pressed_r;
  logic [BUTTON_COUNT-1:0] released_r;
  logic [TIME_W-1:0]       last_change [BUTTON_COUNT];
  logic [TIME_W-1:0]       elapsed [BUTTON_COUNT];

  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_sample
    if (i < FIELD_BUTTONS) begin : g_pin
      assign sample[i] = pins[i];
    end else begin : g_nopin
      assign sample[i] = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      elapsed[i]     = now - last_change[i];
      take[i]        = elapsed[i] > TIME_W'(window);
      stable_next[i] = take[i] ? sample[i] : stable[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable     <= '0;
      last_level <= '0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        last_change[i] <= '0;
      end
    end else if (update) begin
      stable <= stable_next;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        if (take[i] && (sample[i] != last_level[i])) begin
          last_change[i] <= now;
          last_level[i]  <= sample[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      pressed_r  <= stable & ~stable_next;
      released_r <= ~stable & stable_next;
    end
  end

  for (genvar j = 0; j < FIELD_BUTTONS; j++) begin : g_out
    if (j < BUTTON_COUNT) begin : g_used
      assign stable_out[j] = stable[j];
      assign pressed[j]    = pressed_r[j];
      assign released[j]   = released_r[j];
    end else begin : g_unused
      assign stable_out[j] = 1'b0;
      assign pressed[j]    = 1'b0;
      assign released[j]   = 1'b0;
    end
  end

endmodule

// ----- rtl/joystick_input_conditioner.sv -----
// Joystick input conditioner: top level, configuration and result merge
//
// Input channel in_valid/in_ready carries one poll: four signed ADC codes,
// the raw button levels and a millisecond timestamp. Output channel
// out_valid/out_ready returns one result per poll: four commands in
// 1000..2000, the debounced levels and press/release flags.
// Configuration channel cfg_valid/cfg_ready writes cfg_data to register
// cfg_index (0..3 axis calibration, 4 debounce window); cfg_ready is always
// high and other indexes are dropped.
// Each axis lane scales its code and then runs one 24-step serial division;
// once all lanes are done the result is loaded into the output register,
// and the next poll can be taken in the cycle after that load: one poll in
// the lanes at a time.
// A finished result waits in the output register; a new poll is taken while
// it waits, but the lanes cannot hand over the next one until it is taken.
// Reset restores the calibration (centre 166, range 0..333), a 100 ms window,
// clears the debounce state and empties the output register.
`include "assert_macros.svh"
module joystick_input_conditioner import jic_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [CODE_W-1:0] code_left_x,
  input  logic signed [CODE_W-1:0] code_left_y,
  input  logic signed [CODE_W-1:0] code_right_x,
  input  logic signed [CODE_W-1:0] code_right_y,
  input  logic [FIELD_BUTTONS-1:0] pin_levels,
  input  logic [TIME_W-1:0]        now_ms,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [CMD_W-1:0]         cmd_left_x,
  output logic [CMD_W-1:0]         cmd_left_y,
  output logic [CMD_W-1:0]         cmd_right_x,
  output logic [CMD_W-1:0]         cmd_right_y,
  output logic [FIELD_BUTTONS-1:0] stable_levels,
  output logic [FIELD_BUTTONS-1:0] pressed_flags,
  output logic [FIELD_BUTTONS-1:0] released_flags,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CAL_W-1:0]         cfg_data
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_RUN  = 1'b1;

  logic [0:0]               state;
  logic [CAL_W-1:0]         cal [FIELD_AXES];
  logic [WIN_W-1:0]         debounce_win;
  logic signed [CODE_W-1:0] codes [FIELD_AXES];
  logic [CMD_W-1:0]         lane_cmd [FIELD_AXES];
  lane_status_t             lane_status [FIELD_AXES];
  logic [FIELD_AXES-1:0]    lane_done;
  logic [FIELD_AXES-1:0]    lane_busy;
  logic                     accept;
  logic                     all_done;
  logic                     out_load;
  logic [FIELD_BUTTONS-1:0] db_stable;
  logic [FIELD_BUTTONS-1:0] db_pressed;
  logic [FIELD_BUTTONS-1:0] db_released;

  assign codes[0] = code_left_x;
  assign codes[1] = code_left_y;
  assign codes[2] = code_right_x;
  assign codes[3] = code_right_y;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign all_done  = &lane_done;
  assign out_load  = (state == ST_RUN) && all_done && (!out_valid || out_ready);

  for (genvar i = 0; i < FIELD_AXES; i++) begin : g_axis
    if (i < AXIS_COUNT) begin : g_lane
      jic_axis_lane u_lane (
        .clk    (clk),
        .rst    (rst),
        .start  (accept),
        .code   (codes[i]),
        .cal    (cal[i]),
        .cmd    (lane_cmd[i]),
        .status (lane_status[i])
      );
    end else begin : g_idle_axis
      assign lane_cmd[i]    = CMD_W'(CMD_CENTRE);
      assign lane_status[i] = '{busy: 1'b0, done: 1'b1};
    end
    assign lane_done[i] = lane_status[i].done;
    assign lane_busy[i] = lane_status[i].busy;
  end

  jic_debounce u_debounce (
    .clk        (clk),
    .rst        (rst),
    .update     (accept),
    .pins       (pin_levels),
    .now        (now_ms),
    .window     (debounce_win),
    .stable_out (db_stable),
    .pressed    (db_pressed),
    .released   (db_released)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FIELD_AXES; i++) begin
        cal[i] <= CAL_RESET;
      end
      debounce_win <= DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CAL_LEFT_X:  cal[0] <= cfg_data;
        CFG_CAL_LEFT_Y:  cal[1] <= cfg_data;
        CFG_CAL_RIGHT_X: cal[2] <= cfg_data;
        CFG_CAL_RIGHT_Y: cal[3] <= cfg_data;
        CFG_DEBOUNCE:    debounce_win <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) state <= ST_RUN;
        end
        ST_RUN: begin
          if (out_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cmd_left_x     <= lane_cmd[0];
      cmd_left_y     <= lane_cmd[1];
      cmd_right_x    <= lane_cmd[2];
      cmd_right_y    <= lane_cmd[3];
      stable_levels  <= db_stable;
      pressed_flags  <= db_pressed;
      released_flags <= db_released;
    end
  end

  `ASSERT_PROP(a_accept_starts_lanes, clk, rst, accept |=> lane_busy[0])
  `ASSERT_NEVER(a_idle_lanes_quiet, clk, rst, (state == ST_IDLE) && (|lane_busy))
  `ASSERT_PROP(a_cmd_range, clk, rst, out_valid |-> (cmd_left_x >= CMD_W'(CMD_MIN) && cmd_left_x <= CMD_W'(CMD_MAX)))
  `ASSERT_NEVER(a_press_low, clk, rst, out_valid && (|(pressed_flags & stable_levels)))

endmodule

// ----- tb/joystick_input_conditioner_tb.sv -----
// Self-checking testbench for the joystick input conditioner: calibration, deadband, debounce
`timescale 1ns / 1ps
module joystick_input_conditioner_tb;
  import jic_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 60;
  localparam int V_REACH      = 614;

  typedef struct packed {
    logic [FIELD_AXES-1:0][CODE_W-1:0] code;
    logic [FIELD_BUTTONS-1:0]          pins;
    logic [TIME_W-1:0]                 now;
  } poll_t;

  typedef struct packed {
    logic [FIELD_AXES-1:0][CMD_W-1:0] cmd;
    logic [FIELD_BUTTONS-1:0]         stable;
    logic [FIELD_BUTTONS-1:0]         pressed;
    logic [FIELD_BUTTONS-1:0]         released;
  } cmd_set_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [CODE_W-1:0] code_left_x = '0;
  logic signed [CODE_W-1:0] code_left_y = '0;
  logic signed [CODE_W-1:0] code_right_x = '0;
  logic signed [CODE_W-1:0] code_right_y = '0;
  logic [FIELD_BUTTONS-1:0] pin_levels = '0;
  logic [TIME_W-1:0]        now_ms = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [CMD_W-1:0]         cmd_left_x;
  logic [CMD_W-1:0]         cmd_left_y;
  logic [CMD_W-1:0]         cmd_right_x;
  logic [CMD_W-1:0]         cmd_right_y;
  logic [FIELD_BUTTONS-1:0] stable_levels;
  logic [FIELD_BUTTONS-1:0] pressed_flags;
  logic [FIELD_BUTTONS-1:0] released_flags;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CAL_W-1:0]         cfg_data = '0;

  joystick_input_conditioner DUT (.*);

  always #6 clk = ~clk;

  // predictor copy of registers and debounce state
  logic [FIELD_AXES-1:0][CAL_W-1:0] cal_shadow;
  logic [WIN_W-1:0]                 window_shadow;
  logic [BUTTON_COUNT-1:0]          lvl_stable;
  logic [BUTTON_COUNT-1:0]          lvl_sampled;
  logic [TIME_W-1:0]                change_at [BUTTON_COUNT];

  cmd_set_t                 outputs_due [$];
  int                       bad_fields = 0;
  int                       quiet_cycles = 0;
  bit                       src_jitter = 1'b1;
  bit                       sink_jitter = 1'b1;
  int                       hold_request = 0;
  int                       sink_left = 0;
  logic [TIME_W-1:0]        poll_clock = '0;
  logic [FIELD_BUTTONS-1:0] pin_hold = '0;

  function automatic longint lin_map(longint x, longint in_lo, longint in_hi,
                                     longint out_lo, longint out_hi);
    if (in_hi == in_lo) return out_lo;
    return (x - in_lo) * (out_hi - out_lo) / (in_hi - in_lo) + out_lo;
  endfunction

  function automatic logic [CMD_W-1:0] axis_command(logic [CODE_W-1:0] code,
                                                    logic [CAL_W-1:0] cal);
    longint v, c, lo, hi, m;
    v  = longint'($signed(code)) * 3 / SCALE_DIV;
    c  = longint'($signed(cal[47:32]));
    lo = longint'($signed(cal[31:16]));
    hi = longint'($signed(cal[15:0]));
    if (c - lo < NARROW_SPAN || hi - c < NARROW_SPAN) begin
      m = lin_map(v, 0, NARROW_DEN, CMD_MIN, CMD_MAX);
      if (m < CMD_MIN) m = CMD_MIN;
      else if (m > CMD_MAX) m = CMD_MAX;
    end else if (v >= c) begin
      m = lin_map(v, c, hi, CMD_CENTRE, CMD_MAX);
    end else begin
      m = lin_map(v, lo, c, CMD_MIN, CMD_CENTRE);
    end
    if (m > DEAD_LO && m < DEAD_HI) m = CMD_CENTRE;
    m = INVERT_SUM - m;
    if (m < CMD_MIN) m = CMD_MIN;
    else if (m > CMD_MAX) m = CMD_MAX;
    return m[CMD_W-1:0];
  endfunction

  function automatic cmd_set_t condition_poll(poll_t p);
    cmd_set_t         r;
    logic             prev;
    logic [TIME_W-1:0] since;
    for (int a = 0; a < FIELD_AXES; a++) r.cmd[a] = axis_command(p.code[a], cal_shadow[a]);
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      prev  = lvl_stable[b];
      since = p.now - change_at[b];
      if (since > window_shadow) begin
        if (p.pins[b] != lvl_sampled[b]) begin
          change_at[b]   = p.now;
          lvl_sampled[b] = p.pins[b];
        end
        lvl_stable[b] = p.pins[b];
      end
      r.stable[b]   = lvl_stable[b];
      r.pressed[b]  = prev & ~lvl_stable[b];
      r.released[b] = ~prev & lvl_stable[b];
    end
    return r;
  endfunction

  function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CAL_W-1:0] data);
    if (idx <= CFG_CAL_RIGHT_Y) cal_shadow[idx] = data;
    else if (idx == CFG_DEBOUNCE) window_shadow = data[WIN_W-1:0];
  endfunction

  function automatic int clip(int x, int lo, int hi);
    return (x < lo) ? lo : (x > hi) ? hi : x;
  endfunction

  function automatic logic [CAL_W-1:0] pack_cal(int c, int lo, int hi);
    return {c[15:0], lo[15:0], hi[15:0]};
  endfunction

  function automatic poll_t mk_poll(int lx, int ly, int rx, int ry,
                                    logic [FIELD_BUTTONS-1:0] pins, logic [TIME_W-1:0] now);
    poll_t p;
    p.code[0] = lx[15:0];
    p.code[1] = ly[15:0];
    p.code[2] = rx[15:0];
    p.code[3] = ry[15:0];
    p.pins    = pins;
    p.now     = now;
    return p;
  endfunction

  function automatic logic [CAL_W-1:0] random_cal();
    int          c, lo, hi;
    logic [63:0] raw;
    c  = int'($urandom_range(0, 600)) - 300;
    lo = c - int'($urandom_range(10, 300));
    hi = c + int'($urandom_range(10, 300));
    case ($urandom_range(0, 9))
      6: begin
        lo = c - int'($urandom_range(0, 12));
        hi = c + int'($urandom_range(0, 12));
      end
      7: begin
        lo = int'($urandom_range(0, 1400)) - 700;
        hi = int'($urandom_range(0, 1400)) - 700;
      end
      8: begin
        raw = {$urandom, $urandom};
        return raw[CAL_W-1:0];
      end
      9: begin
        lo = -32768;
        hi = 32767;
      end
      default: ;
    endcase
    return pack_cal(c, lo, hi);
  endfunction

  // codes aimed mostly at the calibrated span and around the centre
  function automatic logic [CODE_W-1:0] axis_stimulus(logic [CAL_W-1:0] cal);
    int c, lo, hi, base, span, v, code;
    c  = int'($signed(cal[47:32]));
    lo = int'($signed(cal[31:16]));
    hi = int'($signed(cal[15:0]));
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        code = $urandom;
        return code[15:0];
      end
      3, 4: v = c + int'($urandom_range(0, 6)) - 3;
      default: begin
        base = (lo < hi) ? lo : hi;
        span = (lo < hi) ? hi - lo : lo - hi;
        if (span > 1300) span = 1300;
        v = base - 20 + int'($urandom_range(0, span + 40));
      end
    endcase
    v    = clip(v, -V_REACH, V_REACH);
    code = clip(v * SCALE_DIV / 3 + int'($urandom_range(0, 52)) - 26, -32768, 32767);
    return code[15:0];
  endfunction

  function automatic poll_t random_poll();
    poll_t p;
    int    roll;
    for (int a = 0; a < FIELD_AXES; a++) p.code[a] = axis_stimulus(cal_shadow[a]);
    roll = $urandom_range(0, 31);
    if (roll == 0) poll_clock = $urandom;
    else if (roll == 1) poll_clock = 32'hFFFF_FFFF - $urandom_range(0, 200);
    else poll_clock = poll_clock + $urandom_range(0, 2 * int'(window_shadow) + 2);
    roll = $urandom_range(0, 9);
    if (roll < 2) pin_hold[$urandom_range(0, FIELD_BUTTONS - 1)] ^= 1'b1;
    p.pins = (roll == 9) ? FIELD_BUTTONS'($urandom) : pin_hold;
    p.now  = poll_clock;
    return p;
  endfunction

  task automatic send_poll(poll_t p);
    bit taken;
    if (src_jitter && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      do repeat ($urandom_range(1, 16)) @(posedge clk);
      while ($urandom_range(0, 2) == 0);
    end
    in_valid     <= 1'b1;
    code_left_x  <= p.code[0];
    code_left_y  <= p.code[1];
    code_right_x <= p.code[2];
    code_right_y <= p.code[3];
    pin_levels   <= p.pins;
    now_ms       <= p.now;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      if (taken) outputs_due.push_back(condition_poll(p));
      @(posedge clk);
    end
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CAL_W-1:0] data);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      if (taken) apply_config(idx, data);
      @(posedge clk);
    end
  endtask

  task automatic program_setup(logic [FIELD_AXES-1:0][CAL_W-1:0] cals, logic [WIN_W-1:0] window);
    cfg_write(CFG_CAL_LEFT_X, cals[0]);
    cfg_write(CFG_CAL_LEFT_Y, cals[1]);
    cfg_write(CFG_CAL_RIGHT_X, cals[2]);
    cfg_write(CFG_CAL_RIGHT_Y, cals[3]);
    cfg_write(CFG_DEBOUNCE, {{(CAL_W-WIN_W){1'b0}}, window});
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk);
  endtask

  task automatic random_setup(logic [WIN_W-1:0] window);
    logic [FIELD_AXES-1:0][CAL_W-1:0] cals;
    for (int a = 0; a < FIELD_AXES; a++) cals[a] = random_cal();
    drain();
    program_setup(cals, window);
  endtask

  task automatic test_power_on_defaults();
    send_poll(mk_poll(0, 0, 0, 0, 4'b0000, 10));
    send_poll(mk_poll(32767, -32768, 8854, 8800, 4'b1111, 50));
    send_poll(mk_poll(-32768, 32767, 17760, -1, 4'b1111, 101));
    send_poll(mk_poll(8854, 100, -100, 1, 4'b0000, 150));
    send_poll(mk_poll(1, 8960, -8960, 17813, 4'b0000, 202));
    send_poll(mk_poll(-53, -54, 53, 54, 4'b0101, 303));
  endtask

  task automatic test_calibration_extremes();
    logic [FIELD_AXES-1:0][CAL_W-1:0] cals;
    cals[0] = pack_cal(0, -32768, 32767);
    cals[1] = pack_cal(100, 91, 400);
    cals[2] = pack_cal(0, 200, -200);
    cals[3] = '1;
    drain();
    program_setup(cals, '0);
    @(posedge clk);
    // writes past the register list must be dropped
    for (int i = CFG_DEBOUNCE + 1; i < 2 ** CFG_IDX_W; i++) cfg_write(i[CFG_IDX_W-1:0], '1);
    cfg_valid <= 1'b0;
    send_poll(mk_poll(32767, -32768, 0, 0, 4'b1111, 1000));
    send_poll(mk_poll(-32768, 32767, 32767, -32768, 4'b0000, 1000));
    send_poll(mk_poll(0, 5333, -5333, 17760, 4'b0000, 1001));
    send_poll(mk_poll(-54, 21333, 10666, -10667, 4'b1010, 1002));
    for (int a = 0; a < FIELD_AXES; a++) cals[a] = pack_cal(-600, -620, -580);
    drain();
    program_setup(cals, 16'hFFFF);
    send_poll(mk_poll(32767, -32768, -32000, 32000, 4'b0101, 70000));
    send_poll(mk_poll(-32000, -32000, -32768, -32768, 4'b1010, 70001));
    send_poll(mk_poll(-31999, -32107, -31466, 0, 4'b1111, 200000));
  endtask

  task automatic test_debounce_window();
    logic [FIELD_AXES-1:0][CAL_W-1:0] cals;
    logic [TIME_W-1:0]                stamps [9];
    logic [FIELD_BUTTONS-1:0]         levels [9];
    poll_t                            p;
    stamps = '{32'hFFFF_FF00, 32'hFFFF_FF05, 32'hFFFF_FF15, 32'hFFFF_FFF8, 32'h0000_0004,
               32'h0000_0010, 32'h0000_0024, 32'h0000_0025, 32'h0000_0039};
    levels = '{4'b0101, 4'b1010, 4'b1010, 4'b0000, 4'b1111,
               4'b1111, 4'b1111, 4'b0000, 4'b1111};
    for (int a = 0; a < FIELD_AXES; a++) cals[a] = CAL_RESET;
    drain();
    program_setup(cals, 16'd20);
    for (int k = 0; k < 9; k++) begin
      p = random_poll();
      p.pins = levels[k];
      p.now  = stamps[k];
      send_poll(p);
    end
    poll_clock = stamps[8];
  endtask

  task automatic test_random_polls(logic [WIN_W-1:0] window, int count);
    random_setup(window);
    repeat (count) send_poll(random_poll());
  endtask

  task automatic test_output_backpressure(int count);
    random_setup(WIN_W'($urandom_range(1, 300)));
    hold_request = HOLD_CYCLES;
    repeat (count) send_poll(random_poll());
  endtask

  task automatic test_unthrottled_tail(int count);
    src_jitter  = 1'b0;
    sink_jitter = 1'b0;
    random_setup(WIN_W'($urandom_range(0, 500)));
    repeat (count) send_poll(random_poll());
  endtask

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      bad_fields++;
      if (bad_fields <= 10) $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // receiver: random hold-offs plus one long stall on request
  always @(posedge clk) begin
    if (hold_request != 0) begin
      sink_left = hold_request;
      hold_request = 0;
    end
    if (sink_left > 0) begin
      sink_left--;
      out_ready <= 1'b0;
    end else if (sink_jitter && $urandom_range(0, 11) == 0) begin
      sink_left = $urandom_range(1, 16) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(negedge clk) begin : result_check
    cmd_set_t want;
    if (!rst && out_valid && out_ready) begin
      if (outputs_due.size() == 0) begin
        bad_fields++;
        if (bad_fields <= 10) $display("%0t: transaction with no poll outstanding", $time);
      end else begin
        want = outputs_due.pop_front();
        check_field("cmd_left_x", want.cmd[0], cmd_left_x);
        check_field("cmd_left_y", want.cmd[1], cmd_left_y);
        check_field("cmd_right_x", want.cmd[2], cmd_right_x);
        check_field("cmd_right_y", want.cmd[3], cmd_right_y);
        check_field("stable_levels", want.stable, stable_levels);
        check_field("pressed_flags", want.pressed, pressed_flags);
        check_field("released_flags", want.released, released_flags);
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int a = 0; a < FIELD_AXES; a++) cal_shadow[a] = CAL_RESET;
    window_shadow = DEBOUNCE_RESET;
    lvl_stable    = '0;
    lvl_sampled   = '0;
    for (int b = 0; b < BUTTON_COUNT; b++) change_at[b] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_power_on_defaults();
    test_calibration_extremes();
    test_debounce_window();
    test_random_polls('0, 140);
    test_random_polls('1, 140);
    for (int ph = 0; ph < 4; ph++) test_random_polls(WIN_W'($urandom_range(1, 300)), 140);
    test_output_backpressure(140);
    test_unthrottled_tail(140);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_fields == 0 && outputs_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/jic_pkg.sv
rtl/jic_divider.sv
rtl/jic_axis_lane.sv
rtl/jic_debounce.sv
rtl/joystick_input_conditioner.sv
tb/joystick_input_conditioner_tb.sv
